@@ rtl/ashtu_pkg.sv @@
// Constants, types and tables shared by the annular sector hit test unit.
package ashtu_pkg;

  // Vectoring CORDIC: iterations requested, and the length of the arctangent table.
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned TAB_LEN      = 24;
  localparam int unsigned CORDIC_N     = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

  // Pipeline stage numbers.
  localparam int unsigned S_DELTA = 0;             // offsets from the centre
  localparam int unsigned S_PRE   = 1;             // squares, pre-rotation
  localparam int unsigned S_ROUND = CORDIC_N + 2;  // angle rounded to 1/64 degree
  localparam int unsigned S_WRAP  = CORDIC_N + 3;  // angle moved into the window around start
  localparam int unsigned S_OUT   = CORDIC_N + 4;  // output register
  localparam int unsigned N_STAGE = CORDIC_N + 5;

  // Datapath widths.
  localparam int unsigned CW       = 45;  // CORDIC x/y, offsets scaled by 2^24
  localparam int unsigned SCALE_SH = 24;
  localparam int unsigned ZW       = 32;  // angle accumulator, 2^-22 degree units

  localparam logic signed [ZW-1:0] Z_HALF_TURN = 32'sd754974720;  // 180 degrees

  // Angles in 1/64 degree.
  localparam logic signed [18:0] HALF_TURN = 19'sd11520;
  localparam logic signed [18:0] FULL_TURN = 19'sd23040;
  localparam logic signed [18:0] TWO_TURNS = 19'sd46080;

  // Register indices of the configuration port.
  localparam logic [2:0] REG_CENTER_X       = 3'd0;
  localparam logic [2:0] REG_CENTER_Y       = 3'd1;
  localparam logic [2:0] REG_ARC_RADIUS     = 3'd2;
  localparam logic [2:0] REG_BAND_THICKNESS = 3'd3;
  localparam logic [2:0] REG_START_DEG      = 3'd4;
  localparam logic [2:0] REG_END_DEG        = 3'd5;
  localparam logic [2:0] REG_SHOWN          = 3'd6;

  // atan(2^-i) in degrees, scaled by 2^22.
  localparam logic signed [ZW-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
    32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
    32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
    32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
    32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
    32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
    32'sd229,       32'sd115,       32'sd57,       32'sd29
  };

  // Flags that travel with an item through the CORDIC stages.
  typedef struct packed {
    logic zero;  // point sits on the centre
    logic rad;   // radial test passed and arc shown
  } side_t;

endpackage

@@ rtl/annular_sector_hit_test_unit.sv @@
// Annular sector hit test: one query point per cycle while the result output is not stalled,
// through a pipelined vectoring CORDIC.
// One CORDIC iteration per pipeline stage.
// Each stage holds its item while the next one is full and stalled, so bubbles close up.
// Reset (asynchronous, active low) empties the pipeline and loads the register defaults:
// centre 0, radius 0, thickness 1.0, start 0, end 90 degrees, arc shown.
module annular_sector_hit_test_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // query points
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] point_x, [31:16] point_y
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] hit, [7:1] zero
);
  import ashtu_pkg::*;

  // ---------------------------------------------------------------- configuration
  logic signed [15:0] cx_q, cy_q, start_q, end_q;
  logic [15:0]        radius_q, thick_q;
  logic               shown_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      radius_q <= '0;
      thick_q  <= 16'd16;
      start_q  <= '0;
      end_q    <= 16'sd5760;
      shown_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CENTER_X:       cx_q     <= cfg_data_i;
        REG_CENTER_Y:       cy_q     <= cfg_data_i;
        REG_ARC_RADIUS:     radius_q <= cfg_data_i;
        REG_BAND_THICKNESS: thick_q  <= cfg_data_i;
        REG_START_DEG:      start_q  <= cfg_data_i;
        REG_END_DEG:        end_q    <= cfg_data_i;
        REG_SHOWN:          shown_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  logic [N_STAGE-1:0] vld_q, vld_d, rdy;

  assign rdy[N_STAGE-1] = ~vld_q[N_STAGE-1] | m_axis_tready;
  for (genvar k = 0; k < N_STAGE - 1; k++) begin : g_rdy
    assign rdy[k] = ~vld_q[k] | rdy[k+1];
  end

  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) vld_d[0] = s_axis_tvalid;
    for (int unsigned k = 1; k < N_STAGE; k++) begin
      if (rdy[k]) vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = rdy[S_DELTA];

  // ---------------------------------------------------------------- stage 0: offsets
  logic signed [15:0] px, py;
  logic signed [16:0] dx_d, dy_d, dx_q, dy_q;

  assign px   = s_axis_tdata[15:0];
  assign py   = s_axis_tdata[31:16];
  assign dx_d = {px[15], px} - {cx_q[15], cx_q};
  assign dy_d = {py[15], py} - {cy_q[15], cy_q};

  always_ff @(posedge clk_i) begin
    if (rdy[S_DELTA]) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  // ---------------------------------------------------------------- stage 1: squares
  logic signed [33:0] dxx_full, dyy_full;
  logic [31:0]        dxx_q, dyy_q;
  logic signed [18:0] inner_s, outer_s;
  logic [16:0]        inner_c;
  logic [17:0]        outer_c;
  logic [33:0]        in2_d, in2_q;
  logic [35:0]        out2_d, out2_q;

  assign dxx_full = dx_q * dx_q;
  assign dyy_full = dy_q * dy_q;
  // Radii doubled (1/32 pixel) so half the thickness stays exact.
  assign inner_s  = $signed({2'b00, radius_q, 1'b0}) - $signed({3'b000, thick_q});
  assign outer_s  = $signed({2'b00, radius_q, 1'b0}) + $signed({3'b000, thick_q});
  assign inner_c  = inner_s[18] ? 17'd0 : inner_s[16:0];
  assign outer_c  = outer_s[17:0];
  assign in2_d    = inner_c * inner_c;
  assign out2_d   = outer_c * outer_c;

  always_ff @(posedge clk_i) begin
    if (rdy[S_PRE]) begin
      dxx_q  <= dxx_full[31:0];
      dyy_q  <= dyy_full[31:0];
      in2_q  <= in2_d;
      out2_q <= out2_d;
    end
  end

  // ---------------------------------------------------------------- stage 1: pre-rotation
  logic signed [CW-1:0] cx_s [0:CORDIC_N];
  logic signed [CW-1:0] cy_s [0:CORDIC_N];
  logic signed [ZW-1:0] cz_s [0:CORDIC_N];
  side_t                side_q [0:CORDIC_N];

  logic signed [CW-1:0] x0, y0;

  assign x0 = {{(CW-17-SCALE_SH){dx_q[16]}}, dx_q, {SCALE_SH{1'b0}}};
  assign y0 = {{(CW-17-SCALE_SH){dy_q[16]}}, dy_q, {SCALE_SH{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (rdy[S_PRE]) begin
      // Left half-plane: turn by half a turn so the iterations converge.
      if (dx_q[16]) begin
        cx_s[0] <= -x0;
        cy_s[0] <= -y0;
        cz_s[0] <= dy_q[16] ? -Z_HALF_TURN : Z_HALF_TURN;
      end else begin
        cx_s[0] <= x0;
        cy_s[0] <= y0;
        cz_s[0] <= '0;
      end
      side_q[0].zero <= (dx_q == '0) && (dy_q == '0);
      side_q[0].rad  <= 1'b0;
    end
  end

  // Radial test, resolved during the first iteration stage.
  logic [32:0] dsum;
  logic [35:0] d4;
  logic        rad_c;

  assign dsum  = {1'b0, dxx_q} + {1'b0, dyy_q};
  assign d4    = {1'b0, dsum, 2'b00};
  assign rad_c = shown_q && (d4 >= {2'b00, in2_q}) && (d4 <= out2_q);

  // ---------------------------------------------------------------- CORDIC iterations
  for (genvar j = 0; j < CORDIC_N; j++) begin : g_iter
    logic signed [CW-1:0] xsh, ysh, xn, yn;
    logic signed [ZW-1:0] zn;

    assign xsh = cx_s[j] >>> j;
    assign ysh = cy_s[j] >>> j;

    always_comb begin
      if (!cy_s[j][CW-1]) begin
        xn = cx_s[j] + ysh;
        yn = cy_s[j] - xsh;
        zn = cz_s[j] + ATAN_TAB[j];
      end else begin
        xn = cx_s[j] - ysh;
        yn = cy_s[j] + xsh;
        zn = cz_s[j] - ATAN_TAB[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j+2]) begin
        cx_s[j+1]        <= xn;
        cy_s[j+1]        <= yn;
        cz_s[j+1]        <= zn;
        side_q[j+1].zero <= side_q[j].zero;
        side_q[j+1].rad  <= (j == 0) ? rad_c : side_q[j].rad;
      end
    end
  end

  // ---------------------------------------------------------------- round to 1/64 degree
  logic signed [ZW:0]  zr;
  logic signed [16:0]  ang_q;
  logic                rad_r_q;

  assign zr = {cz_s[CORDIC_N][ZW-1], cz_s[CORDIC_N]} + 33'sd32768;

  always_ff @(posedge clk_i) begin
    if (rdy[S_ROUND]) begin
      ang_q   <= side_q[CORDIC_N].zero ? 17'sd0 : zr[ZW:16];
      rad_r_q <= side_q[CORDIC_N].rad;
    end
  end

  // ---------------------------------------------------------------- wrap around start
  logic signed [18:0] diff, diff_p1, diff_p2, diff_m1, diff_m2, diff_w;
  logic signed [18:0] diff_q;
  logic               rad_w_q;

  assign diff    = {{2{ang_q[16]}}, ang_q} - {{3{start_q[15]}}, start_q};
  assign diff_p1 = diff + FULL_TURN;
  assign diff_p2 = diff + TWO_TURNS;
  assign diff_m1 = diff - FULL_TURN;
  assign diff_m2 = diff - TWO_TURNS;

  always_comb begin
    if (diff < -HALF_TURN) begin
      diff_w = (diff_p1 < -HALF_TURN) ? diff_p2 : diff_p1;
    end else if (diff > HALF_TURN) begin
      diff_w = (diff_m1 > HALF_TURN) ? diff_m2 : diff_m1;
    end else begin
      diff_w = diff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[S_WRAP]) begin
      diff_q  <= diff_w;
      rad_w_q <= rad_r_q;
    end
  end

  // ---------------------------------------------------------------- sector test, output
  logic signed [18:0] ang_w, end_x, start_x;
  logic               after_start, before_end, in_sector;
  logic               hit_q;

  assign start_x     = {{3{start_q[15]}}, start_q};
  assign end_x       = {{3{end_q[15]}}, end_q};
  assign ang_w       = start_x + diff_q;
  assign after_start = ~diff_q[18];
  assign before_end  = (ang_w <= end_x);
  assign in_sector   = (start_x <= end_x) ? (after_start && before_end)
                                          : (after_start || before_end);

  always_ff @(posedge clk_i) begin
    if (rdy[S_OUT]) begin
      hit_q <= rad_w_q && in_sector;
    end
  end

  assign m_axis_tvalid = vld_q[S_OUT];
  assign m_axis_tdata  = {7'b0000000, hit_q};

endmodule
